### rtl/dlr_pkg.sv
// Shared types, codes and constants of the dual logistic response block.
// Also holds the constant functions that build the sigmoid table at elaboration.
// No dependencies.
`default_nettype none

package dlr_pkg;

    typedef enum logic [2:0] {
        REG_LEVEL_LOW     = 3'd0,
        REG_LEVEL_MID     = 3'd1,
        REG_LEVEL_HIGH    = 3'd2,
        REG_FIRST_WIDTH   = 3'd3,
        REG_SECOND_WIDTH  = 3'd4,
        REG_FIRST_CENTER  = 3'd5,
        REG_SECOND_CENTER = 3'd6
    } dlr_reg_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_ZERO_WIDTH = 2'd1;
    localparam logic [1:0] STATUS_SATURATED  = 2'd2;

    localparam logic [30:0] LN81_Q28   = 31'd1179625921;
    localparam logic [35:0] EIGHT_Q32  = 36'h8_0000_0000;
    localparam int          DIV_STAGES = 31;
    localparam int          LANE_LAT   = DIV_STAGES + 7;

    typedef struct packed {
        logic big;
        logic neg;
    } dlr_arg_t;

    function automatic logic [63:0] cdiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem = rem - {1'b0, b};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [31:0] sig_entry(input int k, input int seg, input int frac);
        logic [63:0] one;
        logic [63:0] e1;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] base;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        int          q;
        int          p;
        one  = 64'd1 << 62;
        e1   = one;
        term = one;
        for (int n = 1; n <= 20; n++) begin
            term = cdiv(term, 64'(seg * n));
            if ((n % 2) == 1) begin
                e1 = e1 - term;
            end else begin
                e1 = e1 + term;
            end
        end
        q    = 16 * k - 8 * seg;
        p    = (q < 0) ? -q : q;
        e    = one;
        base = e1;
        for (int i = 0; i < 16; i++) begin
            if (p != 0) begin
                if ((p % 2) == 1) begin
                    e = mul_q62(e, base);
                end
                base = mul_q62(base, base);
                p    = p / 2;
            end
        end
        num = (q >= 0) ? one : e;
        den = (one + e) >> 30;
        num = num >> 30;
        quo = cdiv((num << frac) + (den >> 1), den);
        return quo[31:0];
    endfunction

endpackage

`default_nettype wire

### rtl/dlr_divider.sv
// Pipelined restoring divider giving floor(num * 2^30 / den), one quotient bit per stage.
// Depends on dlr_pkg for the stage count and the argument side-band type.
`default_nettype none

module dlr_divider
    import dlr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        advance,
    input  wire logic [32:0] num,
    input  wire logic [31:0] den,
    input  wire dlr_arg_t    arg_in,
    output logic      [30:0] quotient,
    output dlr_arg_t         arg_out
);

    logic [32:0] rem_reg [DIV_STAGES];
    logic [30:0] quo_reg [DIV_STAGES];
    logic [31:0] den_reg [DIV_STAGES];
    dlr_arg_t    arg_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        logic [33:0] trial;
        logic [31:0] den_cur;
        logic [30:0] quo_cur;
        dlr_arg_t    arg_cur;
        logic        bit_q;
        logic [32:0] rem_next;
        logic [30:0] quo_next;

        if (i == 0) begin : g_first
            assign trial   = {1'b0, num};
            assign den_cur = den;
            assign quo_cur = '0;
            assign arg_cur = arg_in;
        end else begin : g_rest
            assign trial   = {rem_reg[i-1], 1'b0};
            assign den_cur = den_reg[i-1];
            assign quo_cur = quo_reg[i-1];
            assign arg_cur = arg_reg[i-1];
        end

        always_comb begin
            bit_q    = (trial >= {2'b00, den_cur});
            rem_next = bit_q ? 33'(trial - {2'b00, den_cur}) : trial[32:0];
            quo_next = {quo_cur[29:0], bit_q};
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                rem_reg[i] <= rem_next;
                quo_reg[i] <= quo_next;
                den_reg[i] <= den_cur;
                arg_reg[i] <= arg_cur;
            end
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];
    assign arg_out  = arg_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/dlr_sigmoid.sv
// One sigmoid lane: argument scaling, clamping and table interpolation, fully pipelined.
// Depends on dlr_pkg and instantiates dlr_divider.
`default_nettype none

module dlr_sigmoid
    import dlr_pkg::*;
#(
    parameter int FRAC_BITS        = 16,
    parameter int SIGMOID_SEGMENTS = 64
) (
    input  wire logic               aclk,
    input  wire logic               advance,
    input  wire logic        [31:0] sample,
    input  wire logic        [31:0] center,
    input  wire logic        [31:0] width,
    output logic        [FRAC_BITS:0] sigma
);

    localparam int KW = $clog2(SIGMOID_SEGMENTS + 1);
    localparam int PW = 36 + KW;

    typedef logic [FRAC_BITS:0] tab_t [SIGMOID_SEGMENTS + 1];

    function automatic tab_t build_tab();
        tab_t t;
        for (int k = 0; k <= SIGMOID_SEGMENTS; k++) begin
            t[k] = (FRAC_BITS + 1)'(sig_entry(k, SIGMOID_SEGMENTS, FRAC_BITS));
        end
        return t;
    endfunction

    localparam tab_t SIG_TAB = build_tab();

    logic [32:0]          diff_reg;
    logic [32:0]          mag_d_reg;
    logic [31:0]          mag_w_reg;
    dlr_arg_t             arg_reg;
    logic [30:0]          quo;
    dlr_arg_t             arg_div;
    logic [61:0]          prod_reg;
    dlr_arg_t             arg_mul_reg;
    logic [KW-1:0]        seg_reg;
    logic [31:0]          frac_reg;
    logic [FRAC_BITS:0]   lo_reg;
    logic [FRAC_BITS:0]   step_reg;
    logic [31:0]          frac2_reg;
    logic [FRAC_BITS:0]   lo2_reg;
    logic [FRAC_BITS+32:0] ip_reg;
    logic [FRAC_BITS:0]   sigma_reg;

    logic [32:0]          mag_d_next;
    logic [31:0]          mag_w_next;
    dlr_arg_t             arg_next;
    logic [35:0]          mag_raw;
    logic [35:0]          mag;
    logic [36:0]          up_sum;
    logic [35:0]          xp;
    logic [PW-1:0]        pos;
    logic [KW-1:0]        seg_next;
    logic [FRAC_BITS:0]   tab_lo;
    logic [FRAC_BITS:0]   tab_hi;

    always_comb begin
        mag_d_next   = diff_reg[32] ? 33'(-diff_reg) : diff_reg;
        mag_w_next   = width[31] ? 32'(-width) : width;
        arg_next.neg = diff_reg[32] ^ width[31];
        arg_next.big = (mag_d_next >= {mag_w_next, 1'b0});
    end

    dlr_divider u_div (
        .aclk     (aclk),
        .advance  (advance),
        .num      (mag_d_reg),
        .den      (mag_w_reg),
        .arg_in   (arg_reg),
        .quotient (quo),
        .arg_out  (arg_div)
    );

    always_comb begin
        mag_raw = prod_reg[61:26];
        mag     = (arg_mul_reg.big || (mag_raw > EIGHT_Q32)) ? EIGHT_Q32 : mag_raw;
        up_sum  = {1'b0, EIGHT_Q32} + {1'b0, mag};
        if (arg_mul_reg.neg) begin
            xp = EIGHT_Q32 - mag;
        end else begin
            xp = up_sum[36] ? '1 : up_sum[35:0];
        end
        pos      = PW'(xp) * PW'(SIGMOID_SEGMENTS);
        seg_next = pos[PW-1:36];
        if (seg_next >= KW'(SIGMOID_SEGMENTS)) begin
            seg_next = KW'(SIGMOID_SEGMENTS - 1);
        end
        tab_lo = SIG_TAB[seg_reg];
        tab_hi = SIG_TAB[seg_reg + 1'b1];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            diff_reg    <= {sample[31], sample} - {center[31], center};
            mag_d_reg   <= mag_d_next;
            mag_w_reg   <= mag_w_next;
            arg_reg     <= arg_next;
            prod_reg    <= {31'd0, quo} * {31'd0, LN81_Q28};
            arg_mul_reg <= arg_div;
            seg_reg     <= seg_next;
            frac_reg    <= pos[35:4];
            lo_reg      <= tab_lo;
            step_reg    <= (tab_hi < tab_lo) ? '0 : tab_hi - tab_lo;
            frac2_reg   <= frac_reg;
            lo2_reg     <= lo_reg;
            ip_reg      <= (FRAC_BITS + 33)'(step_reg) * (FRAC_BITS + 33)'(frac2_reg);
            sigma_reg   <= lo2_reg + ip_reg[FRAC_BITS+32:32];
        end
    end

    assign sigma = sigma_reg;

endmodule

`default_nettype wire

### rtl/dual_logistic_response.sv
// Top level of the dual logistic response: configuration registers, two sigmoid lanes,
// level weighting, truncation and saturation. Depends on dlr_pkg and dlr_sigmoid.
//
//  Channel   Direction  Ports                                  Content
//  s_        in         s_valid, s_ready, s_sample_value       sample, Q16.16
//  m_        out        m_valid, m_ready, m_response, m_status response and status
//  cfg_      in         cfg_valid, cfg_ready, cfg_index, cfg_data  register write
//
// One request is taken per cycle unless the output stalls; each result is presented
// through 41 register stages after the edge that accepts its request.
// Most of these stages are those of the 31-stage pipelined divider in each sigmoid lane.
// Reset clears the valid bits and loads the register reset values; no clearing pass.
// A result that is not taken stalls the whole pipeline; nothing is lost or repeated.
`default_nettype none

module dual_logistic_response
    import dlr_pkg::*;
#(
    parameter int FRAC_BITS        = 16,
    parameter int SIGMOID_SEGMENTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_sample_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_response,
    output logic      [1:0]  m_status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int PIPE = LANE_LAT + 3;
    localparam int PRW  = FRAC_BITS + 35;
    localparam int TW   = FRAC_BITS + 37;

    logic [31:0] level_low_reg;
    logic [31:0] level_mid_reg;
    logic [31:0] level_high_reg;
    logic [31:0] first_width_reg;
    logic [31:0] second_width_reg;
    logic [31:0] first_center_reg;
    logic [31:0] second_center_reg;

    logic [PIPE-1:0]       valid_reg;
    logic                  advance;
    logic [FRAC_BITS:0]    sigma1;
    logic [FRAC_BITS:0]    sigma2;
    logic signed [32:0]    diff1;
    logic signed [32:0]    diff2;
    logic signed [PRW-1:0] p1_reg;
    logic signed [PRW-1:0] p2_reg;
    logic signed [TW-1:0]  total_reg;
    logic signed [TW-1:0]  base_term;
    logic signed [36:0]    scaled;
    logic [31:0]           response_reg;
    logic [1:0]            status_reg;
    logic [31:0]           response_next;
    logic [1:0]            status_next;

    assign advance   = !valid_reg[PIPE-1] || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = valid_reg[PIPE-1];
    assign m_response = response_reg;
    assign m_status   = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_low_reg     <= 32'd0;
            level_mid_reg     <= 32'd0;
            level_high_reg    <= 32'd0;
            first_width_reg   <= 32'd65536;
            second_width_reg  <= 32'd65536;
            first_center_reg  <= 32'd0;
            second_center_reg <= 32'd0;
        end else if (cfg_valid) begin
            unique case (dlr_reg_t'(cfg_index))
                REG_LEVEL_LOW:     level_low_reg     <= cfg_data;
                REG_LEVEL_MID:     level_mid_reg     <= cfg_data;
                REG_LEVEL_HIGH:    level_high_reg    <= cfg_data;
                REG_FIRST_WIDTH:   first_width_reg   <= cfg_data;
                REG_SECOND_WIDTH:  second_width_reg  <= cfg_data;
                REG_FIRST_CENTER:  first_center_reg  <= cfg_data;
                REG_SECOND_CENTER: second_center_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[PIPE-2:0], s_valid};
        end
    end

    dlr_sigmoid #(
        .FRAC_BITS        (FRAC_BITS),
        .SIGMOID_SEGMENTS (SIGMOID_SEGMENTS)
    ) u_lane1 (
        .aclk    (aclk),
        .advance (advance),
        .sample  (s_sample_value),
        .center  (first_center_reg),
        .width   (first_width_reg),
        .sigma   (sigma1)
    );

    dlr_sigmoid #(
        .FRAC_BITS        (FRAC_BITS),
        .SIGMOID_SEGMENTS (SIGMOID_SEGMENTS)
    ) u_lane2 (
        .aclk    (aclk),
        .advance (advance),
        .sample  (s_sample_value),
        .center  (second_center_reg),
        .width   (second_width_reg),
        .sigma   (sigma2)
    );

    always_comb begin
        diff1     = $signed({level_mid_reg[31], level_mid_reg})
                  - $signed({level_low_reg[31], level_low_reg});
        diff2     = $signed({level_high_reg[31], level_high_reg})
                  - $signed({level_mid_reg[31], level_mid_reg});
        base_term = TW'($signed(level_low_reg)) <<< FRAC_BITS;
        scaled    = total_reg[TW-1:FRAC_BITS];
        if ((first_width_reg == 32'd0) || (second_width_reg == 32'd0)) begin
            response_next = level_low_reg;
            status_next   = STATUS_ZERO_WIDTH;
        end else if (scaled > 37'sd2147483647) begin
            response_next = 32'h7FFF_FFFF;
            status_next   = STATUS_SATURATED;
        end else if (scaled < -37'sd2147483648) begin
            response_next = 32'h8000_0000;
            status_next   = STATUS_SATURATED;
        end else begin
            response_next = scaled[31:0];
            status_next   = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_reg       <= PRW'(diff1) * PRW'($signed({1'b0, sigma1}));
            p2_reg       <= PRW'(diff2) * PRW'($signed({1'b0, sigma2}));
            total_reg    <= base_term + TW'(p1_reg) + TW'(p2_reg);
            response_reg <= response_next;
            status_reg   <= status_next;
        end
    end

    a_zero_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (first_width_reg == 32'd0)) |->
            (m_status == STATUS_ZERO_WIDTH) && (m_response == level_low_reg))
        else $error("zero width did not return the floor level");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STATUS_SATURATED)) |->
            ((m_response == 32'h7FFF_FFFF) || (m_response == 32'h8000_0000)))
        else $error("saturated result is not at a bound");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(valid_reg))
        else $error("pipeline moved while the result was stalled");

endmodule

`default_nettype wire
